// ===== rtl/mlfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds sizes, codes, state and payload types; no dependencies.
`default_nettype none
package mlfq_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int MAX_LEVELS = 8;
  localparam int SLOT_W     = $clog2(MAX_JOBS);
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int QADDR_W    = LVL_W + SLOT_W;
  localparam int QDEPTH     = MAX_LEVELS * MAX_JOBS;

  localparam logic [0:0] FUNC_ADD  = 1'b0;
  localparam logic [0:0] FUNC_TICK = 1'b1;

  localparam logic [0:0] CFG_NUM_LEVELS = 1'b0;
  localparam logic [0:0] CFG_ALLOTMENT  = 1'b1;

  localparam logic [3:0]  NUM_LEVELS_RST = 4'd3;
  localparam logic [7:0]  ALLOTMENT_RST  = 8'd5;
  localparam logic [15:0] TIME_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [0:0]  func;
    logic [7:0]  job_id;
    logic [15:0] start_time;
    logic [15:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic        add_accepted;
    logic        ran;
    logic [7:0]  run_id;
    logic [2:0]  run_level;
    logic        job_done;
    logic        job_demoted;
    logic [15:0] time_now;
    logic        idle;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_PUSH,
    ST_FINISH
  } eng_state_t;

endpackage
`default_nettype wire

// ===== rtl/mlfq_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler.
// Instantiates mlfq_front and mlfq_engine; depends on mlfq_pkg.
`default_nettype none
// The block keeps up to 16 jobs in 8 FIFO priority levels. An add transaction
// stores a job at the tail of level 0. A tick transaction scans the levels
// from level 0 down, reading each queued slot number from the level queue
// memory through its single registered read port before its start time can be
// compared. Removing a job from the middle of a level moves each later entry
// up by one, and a job that ran and is not done is then re-queued. A two-entry
// input queue takes new transactions while the sequencer works, and the
// result register holds a finished transaction while the next one proceeds.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not
// enforce.
module mlfq_scheduler import mlfq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  // Transactions queued between the front and the sequencer.
  logic     deq_valid;
  logic     deq_ready;
  in_item_t deq_data;

  mlfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_data  (deq_data)
  );

  mlfq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_data  (deq_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/mlfq_front.sv =====
// Front end of the scheduler: a two-entry transaction queue.
// Depends on mlfq_pkg for the input item type.
`default_nettype none
module mlfq_front import mlfq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          deq_valid,
  input  wire logic     deq_ready,
  output in_item_t      deq_data
);

  in_item_t   buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign deq_valid = (cnt_r != 2'd0);
  assign deq_data  = buf_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= in_data;
  end

endmodule
`default_nettype wire

// ===== rtl/mlfq_engine.sv =====
// Back end of the scheduler: job table, level queue memory, pick sequencer
// and the result register. Depends on mlfq_pkg.
`default_nettype none
module mlfq_engine import mlfq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       deq_valid,
  output logic            deq_ready,
  input  wire in_item_t   deq_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(MAX_LEVELS - 1);

  eng_state_t state_r, state_nxt;

  logic [3:0]  num_levels_r;
  logic [7:0]  allot_cfg_r;
  logic [15:0] time_r;

  logic [MAX_JOBS-1:0] slot_used_r;
  logic [7:0]          job_ident_r     [MAX_JOBS];
  logic [15:0]         job_start_r     [MAX_JOBS];
  logic [15:0]         job_remaining_r [MAX_JOBS];
  logic [7:0]          job_allot_r     [MAX_JOBS];
  logic [SLOT_W-1:0]   head_r          [MAX_LEVELS];
  logic [CNT_W-1:0]    count_r         [MAX_LEVELS];

  logic [SLOT_W-1:0] qmem [QDEPTH];
  logic [SLOT_W-1:0] q_rdata_r;
  logic              q_we;
  logic [QADDR_W-1:0] q_waddr, q_raddr;
  logic [SLOT_W-1:0] q_wdata;

  logic [LVL_W-1:0]  lvl_r, nl_r;
  logic [CNT_W-1:0]  k_r, m_r, old_cnt_r;
  logic [SLOT_W-1:0] slot_r;
  logic              done_r;
  logic [15:0]       tnow_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [SLOT_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_cnt;
  logic [SLOT_W-1:0] free_slot;
  logic              have_free;
  logic              hit;
  logic              need_shift;
  logic              fin_done;
  logic              take;
  logic [7:0]        eff_allot;
  logic [3:0]        eff_levels;
  logic [LVL_W-1:0]  nl;
  out_item_t         res_start;
  out_item_t         res_hit;
  out_item_t         res_fin;

  assign cur_head  = head_r[lvl_r];
  assign cur_cnt   = count_r[lvl_r];
  assign hit       = (job_start_r[q_rdata_r] <= tnow_r);
  assign need_shift = (k_r != '0) && (5'(k_r + 5'd1) < cur_cnt);
  assign fin_done  = (job_remaining_r[q_rdata_r] <= 16'd1);
  assign take      = !out_valid_r || !out_stall;
  assign eff_allot = (allot_cfg_r == 8'd0) ? 8'd1 : allot_cfg_r;
  assign eff_levels = (num_levels_r == 4'd0) ? 4'd1 :
                      (num_levels_r > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : num_levels_r;
  assign nl = (4'({1'b0, lvl_r} + 4'd1) < eff_levels) ? LVL_W'(lvl_r + 1'b1) : lvl_r;

  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_slot = SLOT_W'(i);
        have_free = 1'b1;
      end
    end
  end

  // Result fields as they stand when a transaction starts, when a job is
  // picked and when the result is handed over.
  always_comb begin
    res_start              = '0;
    res_start.add_accepted = (deq_data.func == FUNC_ADD) && have_free;
  end

  always_comb begin
    res_hit             = res_r;
    res_hit.ran         = 1'b1;
    res_hit.run_id      = job_ident_r[q_rdata_r];
    res_hit.run_level   = 3'(lvl_r);
    res_hit.job_done    = fin_done;
    res_hit.job_demoted = !fin_done && (job_allot_r[q_rdata_r] <= 8'd1);
  end

  always_comb begin
    res_fin          = res_r;
    res_fin.time_now = tnow_r;
    res_fin.idle     = (slot_used_r == '0);
  end

  always_comb begin
    state_nxt = state_r;
    deq_ready = 1'b0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_raddr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (deq_valid) begin
          deq_ready = 1'b1;
          if (deq_data.func == FUNC_ADD) begin
            state_nxt = ST_FINISH;
            if (have_free) begin
              q_we    = 1'b1;
              q_waddr = {LVL_W'(0), SLOT_W'(head_r[0] + count_r[0][SLOT_W-1:0])};
              q_wdata = free_slot;
            end
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (k_r >= cur_cnt) begin
          if (lvl_r == LAST_LVL) state_nxt = ST_FINISH;
        end else begin
          q_raddr   = {lvl_r, SLOT_W'(cur_head + k_r[SLOT_W-1:0])};
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          if (need_shift)    state_nxt = ST_SH_RD;
          else if (fin_done) state_nxt = ST_FINISH;
          else               state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SH_RD: begin
        q_raddr   = {lvl_r, SLOT_W'(cur_head + m_r[SLOT_W-1:0] + 1'b1)};
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = {lvl_r, SLOT_W'(cur_head + m_r[SLOT_W-1:0])};
        q_wdata = q_rdata_r;
        if (5'(m_r + 5'd2) < old_cnt_r) state_nxt = ST_SH_RD;
        else if (done_r)               state_nxt = ST_FINISH;
        else                           state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        q_we      = 1'b1;
        q_waddr   = {lvl_r, SLOT_W'(cur_head + cur_cnt[SLOT_W-1:0])};
        q_wdata   = slot_r;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Queue memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata_r <= qmem[q_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_levels_r <= NUM_LEVELS_RST;
      allot_cfg_r  <= ALLOTMENT_RST;
      time_r       <= '0;
      slot_used_r  <= '0;
      out_valid_r  <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_LEVELS: num_levels_r <= cfg_wdata[3:0];
          CFG_ALLOTMENT:  allot_cfg_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_FINISH && take)   out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (deq_valid) begin
            if (deq_data.func == FUNC_ADD) begin
              if (have_free) begin
                slot_used_r[free_slot] <= 1'b1;
                count_r[0] <= CNT_W'(count_r[0] + 1'b1);
              end
            end else if (time_r != TIME_MAX) begin
              time_r <= 16'(time_r + 16'd1);
            end
          end
        end
        ST_SCAN_CMP: begin
          if (hit) begin
            count_r[lvl_r] <= CNT_W'(cur_cnt - 1'b1);
            if (k_r == '0) head_r[lvl_r] <= SLOT_W'(cur_head + 1'b1);
            if (fin_done) slot_used_r[q_rdata_r] <= 1'b0;
          end
        end
        ST_PUSH: count_r[lvl_r] <= CNT_W'(cur_cnt + 1'b1);
        default: ;
      endcase
    end
  end

  // Job table and sequencer working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (deq_valid) begin
          tnow_r <= time_r;
          lvl_r  <= '0;
          k_r    <= '0;
          res_r  <= res_start;
          if (deq_data.func == FUNC_ADD && have_free) begin
            job_ident_r[free_slot]     <= deq_data.job_id;
            job_start_r[free_slot]     <= deq_data.start_time;
            job_remaining_r[free_slot] <= deq_data.run_length;
            job_allot_r[free_slot]     <= eff_allot;
          end
        end
      end
      ST_SCAN_RD: begin
        if (k_r >= cur_cnt && lvl_r != LAST_LVL) begin
          lvl_r <= LVL_W'(lvl_r + 1'b1);
          k_r   <= '0;
        end
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          slot_r    <= q_rdata_r;
          m_r       <= k_r;
          old_cnt_r <= cur_cnt;
          done_r    <= fin_done;
          res_r     <= res_hit;
          if (fin_done) begin
            job_remaining_r[q_rdata_r] <= '0;
          end else begin
            job_remaining_r[q_rdata_r] <= 16'(job_remaining_r[q_rdata_r] - 16'd1);
            if (job_allot_r[q_rdata_r] <= 8'd1) begin
              job_allot_r[q_rdata_r] <= eff_allot;
              nl_r                   <= nl;
              if (!need_shift) lvl_r <= nl;
            end else begin
              job_allot_r[q_rdata_r] <= 8'(job_allot_r[q_rdata_r] - 8'd1);
              nl_r                   <= lvl_r;
            end
          end
        end else begin
          k_r <= CNT_W'(k_r + 1'b1);
        end
      end
      ST_SH_WR: begin
        m_r <= CNT_W'(m_r + 1'b1);
        if (!(5'(m_r + 5'd2) < old_cnt_r)) lvl_r <= nl_r;
      end
      ST_FINISH: begin
        if (take) out_data_r <= res_fin;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
